>>> src/ctkd_pkg.sv
package ctkd_pkg;

  // field widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned ScanCntW  = 4;
  localparam int unsigned HoldW     = 4;
  localparam int unsigned CalSumW   = 21;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // calibration sample count default
  localparam int unsigned CalSamplesDefault = 10;

  // register reset values
  localparam logic [SampleW-1:0]  GateReset       = 16'd100;
  localparam logic [ScanCntW-1:0] SingleReset     = 4'd3;
  localparam logic [ScanCntW-1:0] ContinuousReset = 4'd6;
  localparam logic [HoldW-1:0]    HoldReloadReset = 4'd3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegGate       = 2'd0,
    RegSingle     = 2'd1,
    RegContinuous = 2'd2,
    RegHoldReload = 2'd3
  } cfg_reg_e;

  // event kinds
  typedef enum logic {
    EvCalDone  = 1'b0,
    EvScanDone = 1'b1
  } event_kind_e;

  // one result
  typedef struct packed {
    event_kind_e        kind;
    logic               pressed;
    logic [SampleW-1:0] baseline;
    logic               failed;
    logic [SampleW-1:0] smax;
  } result_t;

endpackage

>>> src/capacitive_touch_key_detector.sv
// Capacitive touch key detector core. Each request carries one measured pad charge time.
// After reset, or on a request with recalibrate set, CalSamples samples build the baseline
// (mean of all but the two lowest and two highest); the last one gives a calibration event.
// Later samples are grouped into scans whose maximum is compared against baseline plus the
// gate; a scan end gives a scan event with the press flag. One sample is taken every cycle,
// except that the input stalls while the skid register holds a result and in the cycle right
// after the last calibration sample, while the baseline division (a registered multiply by
// the reciprocal) completes. Results leave through an output register backed by a skid
// register, so the input keeps flowing while one result waits. Configuration is always ready.
module capacitive_touch_key_detector_core
  import ctkd_pkg::*;
#(
  parameter int unsigned CalSamples = CalSamplesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample request
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  charge_time_i,
  input  logic                mode_i,
  input  logic                recalibrate_i,
  // result
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_kind_o,
  output logic                pressed_o,
  output logic [SampleW-1:0]  baseline_value_o,
  output logic                calibration_failed_o,
  output logic [SampleW-1:0]  scan_maximum_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CalCntW = $clog2(CalSamples + 1);
  localparam int unsigned CalDiv  = CalSamples - 4;
  localparam int unsigned DivL    = $clog2(CalDiv);
  localparam int unsigned DivMW   = CalSumW + 1;
  localparam int unsigned ProdW   = CalSumW + DivMW;
  localparam logic [DivMW-1:0] DivM =
    DivMW'(((64'd1 << (CalSumW + DivL)) + 64'(CalDiv) - 64'd1) / 64'(CalDiv));

  // configuration registers
  logic [SampleW-1:0]  gate_q;
  logic [ScanCntW-1:0] single_q;
  logic [ScanCntW-1:0] cont_q;
  logic [HoldW-1:0]    reload_q;

  // detector state
  logic                calibrating_q, calibrating_d;
  logic [CalCntW-1:0]  cal_cnt_q, cal_cnt_d;
  logic [CalSumW-1:0]  cal_sum_q, cal_sum_d;
  logic [SampleW-1:0]  lo0_q, lo0_d, lo1_q, lo1_d;
  logic [SampleW-1:0]  hi0_q, hi0_d, hi1_q, hi1_d;
  logic [SampleW-1:0]  baseline_q;
  logic [ScanCntW-1:0] scan_cnt_q, scan_cnt_d;
  logic [SampleW-1:0]  rmax_q, rmax_d;
  logic                scan_cont_q, scan_cont_d;
  logic [HoldW-1:0]    hold_q, hold_d;

  // division stage
  logic                div_pend_q;
  logic [CalSumW-1:0]  mid_q, mid_d;
  logic [ProdW-1:0]    prod;
  logic [SampleW-1:0]  quot;

  // output buffer
  logic                o_valid_q, s_valid_q;
  result_t             o_res_q, s_res_q;

  // per-request combinational signals
  logic                accept;
  logic                cal_done;
  logic                scan_push;
  result_t             scan_res;
  logic                push;
  result_t             push_res;

  logic                calib_b;
  logic [CalCntW-1:0]  cnt_b, cnt_n;
  logic [CalSumW-1:0]  sum_b, sum_n;
  logic [SampleW-1:0]  l0_b, l1_b, h0_b, h1_b;
  logic [ScanCntW-1:0] sc_b, sc_n, n_sel, n_eff;
  logic [SampleW-1:0]  rm_b, rm_n;
  logic                cont_n;
  logic [HoldW-1:0]    hold_b, hold_n;
  logic                touch;
  logic [SampleW:0]    limit;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = s_valid_q | div_pend_q;
  assign cfg_ready_o = 1'b1;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q   <= GateReset;
      single_q <= SingleReset;
      cont_q   <= ContinuousReset;
      reload_q <= HoldReloadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegGate:       gate_q   <= cfg_data_i;
        RegSingle:     single_q <= cfg_data_i[ScanCntW-1:0];
        RegContinuous: cont_q   <= cfg_data_i[ScanCntW-1:0];
        RegHoldReload: reload_q <= cfg_data_i[HoldW-1:0];
        default:       gate_q   <= gate_q;
      endcase
    end
  end

  // per-sample update: calibration or scan
  always_comb begin
    calibrating_d = calibrating_q;
    cal_cnt_d     = cal_cnt_q;
    cal_sum_d     = cal_sum_q;
    lo0_d         = lo0_q;
    lo1_d         = lo1_q;
    hi0_d         = hi0_q;
    hi1_d         = hi1_q;
    scan_cnt_d    = scan_cnt_q;
    rmax_d        = rmax_q;
    scan_cont_d   = scan_cont_q;
    hold_d        = hold_q;
    mid_d         = mid_q;
    cal_done      = 1'b0;
    scan_push     = 1'b0;

    // recalibrate clears the accumulators and the scan in progress
    calib_b = recalibrate_i | calibrating_q;
    cnt_b   = recalibrate_i ? '0 : cal_cnt_q;
    sum_b   = recalibrate_i ? '0 : cal_sum_q;
    l0_b    = recalibrate_i ? '1 : lo0_q;
    l1_b    = recalibrate_i ? '1 : lo1_q;
    h0_b    = recalibrate_i ? '0 : hi0_q;
    h1_b    = recalibrate_i ? '0 : hi1_q;
    sc_b    = recalibrate_i ? '0 : scan_cnt_q;
    rm_b    = recalibrate_i ? '0 : rmax_q;

    // calibration accumulate
    sum_n = sum_b + CalSumW'(charge_time_i);
    cnt_n = cnt_b + 1'b1;

    // scan step, with mode latched at scan start
    cont_n = (sc_b == '0) ? mode_i : scan_cont_q;
    hold_b = ((sc_b == '0) && mode_i) ? '0 : hold_q;
    rm_n   = (sc_b == '0) ? charge_time_i
           : ((charge_time_i > rm_b) ? charge_time_i : rm_b);
    sc_n   = sc_b + 1'b1;
    n_sel  = cont_n ? cont_q : single_q;
    n_eff  = (n_sel == '0) ? ScanCntW'(1) : n_sel;
    limit  = {1'b0, baseline_q} + {1'b0, gate_q};
    touch  = {1'b0, rm_n} > limit;
    hold_n = touch ? reload_q : hold_b;
    if (hold_n != '0) begin
      hold_n = hold_n - 1'b1;
    end

    scan_res.kind     = EvScanDone;
    scan_res.pressed  = touch && (hold_b == '0);
    scan_res.baseline = baseline_q;
    scan_res.failed   = baseline_q[SampleW-1];
    scan_res.smax     = rm_n;

    if (accept) begin
      if (calib_b) begin
        cal_sum_d  = sum_n;
        // keep the two lowest and two highest samples
        if (charge_time_i < l0_b) begin
          lo1_d = l0_b;
          lo0_d = charge_time_i;
        end else if (charge_time_i < l1_b) begin
          lo1_d = charge_time_i;
          lo0_d = l0_b;
        end else begin
          lo1_d = l1_b;
          lo0_d = l0_b;
        end
        if (charge_time_i > h0_b) begin
          hi1_d = h0_b;
          hi0_d = charge_time_i;
        end else if (charge_time_i > h1_b) begin
          hi1_d = charge_time_i;
          hi0_d = h0_b;
        end else begin
          hi1_d = h1_b;
          hi0_d = h0_b;
        end
        scan_cnt_d = '0;
        rmax_d     = rm_b;
        if (cnt_n == CalCntW'(CalSamples)) begin
          cal_done      = 1'b1;
          calibrating_d = 1'b0;
          cal_cnt_d     = '0;
          rmax_d        = '0;
          // extremes summed as a tree, then removed in one subtraction
          mid_d = sum_n - ((CalSumW'(lo0_d) + CalSumW'(lo1_d))
                         + (CalSumW'(hi0_d) + CalSumW'(hi1_d)));
        end else begin
          calibrating_d = 1'b1;
          cal_cnt_d     = cnt_n;
        end
      end else begin
        scan_cont_d = cont_n;
        rmax_d      = rm_n;
        if ((sc_n == '0) || (sc_n >= n_eff)) begin
          scan_push  = 1'b1;
          hold_d     = hold_n;
          scan_cnt_d = '0;
        end else begin
          hold_d     = hold_b;
          scan_cnt_d = sc_n;
        end
      end
    end
  end

  // baseline division by multiplying with the reciprocal
  assign prod = ProdW'(mid_q) * ProdW'(DivM);
  assign quot = prod[CalSumW+DivL +: SampleW];

  // result source: either the scan end or the finished division
  always_comb begin
    push = scan_push | div_pend_q;
    if (div_pend_q) begin
      push_res.kind     = EvCalDone;
      push_res.pressed  = 1'b0;
      push_res.baseline = quot;
      push_res.failed   = quot[SampleW-1];
      push_res.smax     = '0;
    end else begin
      push_res = scan_res;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrating_q <= 1'b1;
      cal_cnt_q     <= '0;
      cal_sum_q     <= '0;
      lo0_q         <= '1;
      lo1_q         <= '1;
      hi0_q         <= '0;
      hi1_q         <= '0;
      baseline_q    <= '0;
      scan_cnt_q    <= '0;
      rmax_q        <= '0;
      scan_cont_q   <= 1'b0;
      hold_q        <= '0;
      div_pend_q    <= 1'b0;
    end else begin
      calibrating_q <= calibrating_d;
      cal_cnt_q     <= cal_cnt_d;
      cal_sum_q     <= cal_sum_d;
      lo0_q         <= lo0_d;
      lo1_q         <= lo1_d;
      hi0_q         <= hi0_d;
      hi1_q         <= hi1_d;
      scan_cnt_q    <= scan_cnt_d;
      rmax_q        <= rmax_d;
      scan_cont_q   <= scan_cont_d;
      hold_q        <= hold_d;
      div_pend_q    <= cal_done;
      if (div_pend_q) begin
        baseline_q <= quot;
      end
    end
  end

  // trimmed-sum register feeding the divider
  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (!o_valid_q || !out_stall_i) begin
      if (s_valid_q) begin
        o_valid_q <= 1'b1;
        s_valid_q <= push;
      end else begin
        o_valid_q <= push;
      end
    end else if (push) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_valid_q || !out_stall_i) begin
      if (s_valid_q) begin
        o_res_q <= s_res_q;
        if (push) begin
          s_res_q <= push_res;
        end
      end else if (push) begin
        o_res_q <= push_res;
      end
    end else if (push) begin
      s_res_q <= push_res;
    end
  end

  assign out_valid_o          = o_valid_q;
  assign event_kind_o         = o_res_q.kind;
  assign pressed_o            = o_res_q.pressed;
  assign baseline_value_o     = o_res_q.baseline;
  assign calibration_failed_o = o_res_q.failed;
  assign scan_maximum_o       = o_res_q.smax;

  // the skid only fills behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_valid_q |-> o_valid_q)
    else $error("skid holds a result while output register is empty");

  // the division result always finds room
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_pend_q |-> !s_valid_q)
    else $error("baseline result pushed into a full skid");

  // the division pending flag clears in the following cycle; new samples are stalled while it is set
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_pend_q |=> !div_pend_q)
    else $error("division pending for more than one cycle");

  // no scan runs while calibrating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    calibrating_q |-> (scan_cnt_q == '0))
    else $error("scan count moved during calibration");

endmodule
